@@ hdl/assert_macros.svh @@
// Assertion macros shared by the syncpoint interrupt router RTL.
// Standalone header; no dependencies. Empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define SIR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled during reset.
`define SIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define SIR_ASSERT_SAME(label, clk, rst, ante, cons)
`define SIR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hdl/sir_pkg.sv @@
// Package for the syncpoint interrupt router: operation codes, constants
// and the bit interleaving helpers. No dependencies.
package sir_pkg;

  localparam int SYNCPOINT_COUNT_DEF = 32;
  localparam int SUMMARY_SHIFT       = 30;
  localparam int HALF_BITS           = 16;

  typedef enum logic [2:0] {
    KIND_RD_SUMMARY = 3'd0,
    KIND_RD_STATUS  = 3'd1,
    KIND_RD_ROUTE   = 3'd2,
    KIND_ENABLE     = 3'd3,
    KIND_SET_ROUTE  = 3'd4,
    KIND_CLR_ROUTE  = 3'd5,
    KIND_RAISE      = 3'd6,
    KIND_CLR_STATUS = 3'd7
  } kind_t;

  // Interleave two 16-bit halves: CPU bit j to bit 2j, coprocessor bit j to 2j+1.
  function automatic logic [31:0] interleave(input logic [HALF_BITS-1:0] cpu_half,
                                             input logic [HALF_BITS-1:0] cop_half);
    logic [31:0] r;
    r = '0;
    for (int j = 0; j < HALF_BITS; j++) begin
      r[2*j]   = cpu_half[j];
      r[2*j+1] = cop_half[j];
    end
    return r;
  endfunction

  // Even bits of a word, packed down to 16 bits.
  function automatic logic [HALF_BITS-1:0] even_bits(input logic [31:0] w);
    logic [HALF_BITS-1:0] r;
    for (int j = 0; j < HALF_BITS; j++) begin
      r[j] = w[2*j];
    end
    return r;
  endfunction

  // Odd bits of a word, packed down to 16 bits.
  function automatic logic [HALF_BITS-1:0] odd_bits(input logic [31:0] w);
    logic [HALF_BITS-1:0] r;
    for (int j = 0; j < HALF_BITS; j++) begin
      r[j] = w[2*j+1];
    end
    return r;
  endfunction

endpackage

@@ hdl/syncpoint_irq_router_unit.sv @@
// Syncpoint interrupt router, top level: input register, one pass of update
// logic over the route/status words, result register. Uses sir_pkg and
// assert_macros.svh.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------------------
//   item in | in        | start high, busy low  | kind, target_cpu, word_index, bit_mask,
//           |           |                       | syncpoint_id, crossed_bits
//   result  | out       | done for one cycle    | read_data, cpu_line, cop_line,
//           |           |                       | index_error
//
// Every accepted item gives exactly one result: the input register is loaded
// first, then the word state is updated and the result register is loaded. A new
// item may be accepted at every edge while busy is low; the state is written at
// the same edge that a following item enters the input register, so back-to-back
// items always see each other's updates.
// Reset is synchronous and active high; it clears the summary, route and
// status words. busy is high during reset and until the first edge after it, and
// low otherwise. The receiver cannot stall: done is a single-cycle strobe.
`include "assert_macros.svh"

module syncpoint_irq_router_unit #(
  parameter int SYNCPOINT_COUNT = sir_pkg::SYNCPOINT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic        target_cpu,
  input  logic [3:0]  word_index,
  input  logic [31:0] bit_mask,
  input  logic [7:0]  syncpoint_id,
  input  logic [31:0] crossed_bits,
  output logic        done,
  output logic [31:0] read_data,
  output logic        cpu_line,
  output logic        cop_line,
  output logic        index_error
);
  import sir_pkg::*;

  // Number of 32-syncpoint words, and the address width into them.
  localparam int WORDS   = (SYNCPOINT_COUNT + 31) / 32;
  localparam int AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int REM     = SYNCPOINT_COUNT % 32;
  // Existing syncpoints of the last word; all other words are full.
  localparam logic [31:0] LAST_MASK = (REM == 0) ? 32'hFFFF_FFFF
                                                 : ((32'd1 << REM) - 32'd1);

  // Input register.
  logic        q_valid;
  kind_t       q_kind;
  logic        q_cpu;
  logic [3:0]  q_idx;
  logic [31:0] q_mask;
  logic [7:0]  q_sid;
  logic [31:0] q_crossed;

  // Word state.
  logic [1:0]  summary;
  logic [31:0] route_words  [2][WORDS];
  logic [31:0] status_words [2][WORDS];

  // Update logic.
  logic [3:0]  word_sel;
  logic [AW-1:0] addr;
  logic        err;
  logic [31:0] route_cur [2];
  logic [31:0] stat_cur  [2];
  logic [31:0] route_next [2];
  logic [31:0] stat_next  [2];
  logic [1:0]  summary_next;
  logic [31:0] rd_next;
  logic [31:0] raise_bits;
  logic [31:0] existing;
  logic [31:0] hit [2];
  logic [15:0] half_word;
  logic [31:0] keep;
  logic [31:0] clr;
  logic [31:0] cleared;

  // The input fields are taken whenever an item is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
      busy    <= 1'b1;
    end else begin
      q_valid <= start && !busy;
      busy    <= 1'b0;
    end
    if (start && !busy) begin
      q_kind    <= kind_t'(kind);
      q_cpu     <= target_cpu;
      q_idx     <= word_index;
      q_mask    <= bit_mask;
      q_sid     <= syncpoint_id;
      q_crossed <= crossed_bits;
    end
  end

  always_comb begin
    // Word selected by the item: halves address word idx/2, a raise addresses
    // the word that holds the syncpoint, every other kind the word index.
    case (q_kind)
      KIND_RD_ROUTE, KIND_SET_ROUTE: word_sel = {1'b0, q_idx[3:1]};
      KIND_RAISE:                    word_sel = {1'b0, q_sid[7:5]};
      default:                       word_sel = q_idx;
    endcase
    addr = word_sel[AW-1:0];

    // Range check per kind. The summary read never fails.
    case (q_kind)
      KIND_RD_SUMMARY:               err = 1'b0;
      KIND_RD_ROUTE, KIND_SET_ROUTE: err = ({1'b0, q_idx} >= 5'(2 * WORDS));
      KIND_RAISE:                    err = ({1'b0, q_sid} >= 9'(SYNCPOINT_COUNT));
      default:                       err = ({1'b0, q_idx} >= 5'(WORDS));
    endcase

    for (int c = 0; c < 2; c++) begin
      route_cur[c] = route_words[c][addr];
      stat_cur[c]  = status_words[c][addr];
    end

    existing = (32'(addr) == 32'(WORDS - 1)) ? LAST_MASK : 32'hFFFF_FFFF;
    half_word = q_idx[0] ? route_cur[0][31:16] : route_cur[0][15:0];

    route_next   = route_cur;
    stat_next    = stat_cur;
    summary_next = summary;
    rd_next      = '0;
    raise_bits   = '0;
    keep         = '0;
    clr          = '0;
    cleared      = '0;

    case (q_kind)
      KIND_RD_SUMMARY: begin
        rd_next = 32'(summary) << SUMMARY_SHIFT;
      end
      KIND_RD_STATUS: begin
        rd_next = stat_cur[q_cpu];
      end
      KIND_RD_ROUTE: begin
        rd_next = interleave(half_word,
                             q_idx[0] ? route_cur[1][31:16] : route_cur[1][15:0]);
      end
      KIND_ENABLE: begin
        route_next[q_cpu]  = route_cur[q_cpu] | q_mask;
        route_next[!q_cpu] = route_cur[!q_cpu] & ~q_mask;
        raise_bits         = q_mask & q_crossed & existing;
      end
      KIND_SET_ROUTE: begin
        if (q_idx[0]) begin
          route_next[0] = route_cur[0] | {even_bits(q_mask), 16'b0};
          route_next[1] = route_cur[1] | {odd_bits(q_mask), 16'b0};
        end else begin
          route_next[0] = route_cur[0] | {16'b0, even_bits(q_mask)};
          route_next[1] = route_cur[1] | {16'b0, odd_bits(q_mask)};
        end
      end
      KIND_CLR_ROUTE: begin
        route_next[0] = route_cur[0] & ~q_mask;
        route_next[1] = route_cur[1] & ~q_mask;
      end
      KIND_RAISE: begin
        raise_bits = 32'd1 << q_sid[4:0];
      end
      KIND_CLR_STATUS: begin
        // Routed bits that have not crossed yet survive the clear.
        keep    = route_cur[q_cpu] & ~q_crossed;
        clr     = q_mask & ~keep;
        cleared = stat_cur[q_cpu] & ~clr;
        stat_next[q_cpu] = cleared;
        if (cleared == 32'd0) begin
          summary_next[q_cpu] = 1'b0;
        end
      end
      default: begin
        rd_next = '0;
      end
    endcase

    // Raising works on the routes as they stand after this item.
    for (int c = 0; c < 2; c++) begin
      hit[c] = route_next[c] & raise_bits;
      if (hit[c] != 32'd0) begin
        stat_next[c]    = stat_next[c] | hit[c];
        summary_next[c] = 1'b1;
      end
    end

    // An out-of-range item changes nothing and reads as zero.
    if (err) begin
      route_next   = route_cur;
      stat_next    = stat_cur;
      summary_next = summary;
      rd_next      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      summary <= '0;
      done    <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        for (int w = 0; w < WORDS; w++) begin
          route_words[c][w]  <= '0;
          status_words[c][w] <= '0;
        end
      end
    end else begin
      done <= q_valid;
      if (q_valid && !err) begin
        summary <= summary_next;
        for (int c = 0; c < 2; c++) begin
          route_words[c][addr]  <= route_next[c];
          status_words[c][addr] <= stat_next[c];
        end
      end
    end
    if (q_valid) begin
      read_data   <= rd_next;
      cpu_line    <= summary_next[0];
      cop_line    <= summary_next[1];
      index_error <= err;
    end
  end

  // An accepted item reaches the input register and then the result strobe.
  `SIR_ASSERT_NEXT(a_accept_loads, clk, rst, start && !busy, q_valid)
  `SIR_ASSERT_NEXT(a_one_result, clk, rst, q_valid, done)
  // The lines reported with a result match the summary that was stored.
  `SIR_ASSERT_SAME(a_lines_match, clk, rst, done, cpu_line == summary[0] && cop_line == summary[1])
  // A rejected item reads as zero.
  `SIR_ASSERT_SAME(a_err_zero, clk, rst, done && index_error, read_data == 32'd0)

endmodule
